[rtl/gjtg_pkg.sv]
// Shared types, constants and register codes for the gait joint target generator.
package gjtg_pkg;

  localparam int DEF_SINE_TABLE_DEPTH = 256;
  localparam int DEF_PHASE_BITS       = 16;

  localparam int NUM_JOINTS  = 8;
  localparam int ACT_W       = 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // pi/2 in Q2.30 and the Taylor divisors (2n)(2n+1) used to build the sine table
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

  localparam logic signed [15:0] ACT_POS_LIM = 16'sd8192;
  localparam logic signed [15:0] ACT_NEG_LIM = -16'sd8192;

  localparam logic signed [15:0] RST_NEUTRAL_SHOULDER = 16'sd819;
  localparam logic signed [15:0] RST_NEUTRAL_KNEE     = 16'sd5734;
  localparam logic        [14:0] RST_ACTION_GAIN      = 15'd246;
  localparam logic        [14:0] RST_SHOULDER_SWING   = 15'd328;
  localparam logic        [14:0] RST_KNEE_SWING       = 15'd492;
  localparam logic signed [15:0] RST_KNEE_BIAS        = 16'sd0;
  localparam logic        [15:0] RST_PHASE_STEP       = 16'd5461;

  typedef enum logic [2:0] {
    REG_NEUTRAL_SHOULDER = 3'd0,
    REG_NEUTRAL_KNEE     = 3'd1,
    REG_ACTION_GAIN      = 3'd2,
    REG_SHOULDER_SWING   = 3'd3,
    REG_KNEE_SWING       = 3'd4,
    REG_KNEE_BIAS        = 3'd5,
    REG_PHASE_STEP       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] neutral_shoulder;
    logic signed [15:0] neutral_knee;
    logic        [14:0] action_gain;
    logic        [14:0] shoulder_swing;
    logic        [14:0] knee_swing;
    logic signed [15:0] knee_bias;
    logic        [15:0] phase_step;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] joint0_action;
    logic signed [15:0] joint1_action;
    logic signed [15:0] joint2_action;
    logic signed [15:0] joint3_action;
    logic signed [15:0] joint4_action;
    logic signed [15:0] joint5_action;
    logic signed [15:0] joint6_action;
    logic signed [15:0] joint7_action;
  } in_t;

  typedef struct packed {
    logic signed [15:0] joint0_target;
    logic signed [15:0] joint1_target;
    logic signed [15:0] joint2_target;
    logic signed [15:0] joint3_target;
    logic signed [15:0] joint4_target;
    logic signed [15:0] joint5_target;
    logic signed [15:0] joint6_target;
    logic signed [15:0] joint7_target;
    logic signed [15:0] phase_sine;
    logic signed [15:0] phase_cosine;
  } out_t;

  // One classified step: clipped actions and the trig values of its phase
  typedef struct packed {
    logic [NUM_JOINTS-1:0][ACT_W-1:0] act;
    logic signed [15:0]               sine_v;
    logic signed [15:0]               cosine_v;
  } qent_t;

endpackage

[rtl/gait_joint_target_generator_core.sv]
// Top level of the gait joint target generator.
// One action beat per clock is accepted while in_ready is high and one target beat per clock
// is delivered while out_ready is high. A beat enters the two-beat queue when it is accepted,
// then passes the product stage and the sum and saturate stage into the output register.
// With out_ready low the block holds up to four beats (two in the queue, one in the product
// stage, one in the output register); in steady flow the queue holds one beat, so the front
// end takes one more beat after out_ready drops, and in_ready falls only when the queue is
// full. The gait phase starts at zero after reset and advances by
// phase_step on every accepted beat; sine and cosine come from a constant quarter-wave
// table of SINE_TABLE_DEPTH+1 entries with no interpolation. Registers sit at byte address
// 4*index on the APB-style port and should be written only while no beat is in flight.
module gait_joint_target_generator_core #(
  parameter int SINE_TABLE_DEPTH = gjtg_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = gjtg_pkg::DEF_PHASE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gjtg_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gjtg_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gjtg_pkg::PADDR_W-1:0] paddr,
  input  logic [gjtg_pkg::PDATA_W-1:0] pwdata,
  output logic [gjtg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  gjtg_pkg::cfg_t  cfg;
  gjtg_pkg::qent_t q_wdata, q_rdata;
  logic            q_push, q_full, q_pop, q_not_empty;

  assign pready = 1'b1;

  gjtg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  gjtg_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .phase_step (cfg.phase_step),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  gjtg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  gjtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/gjtg_cfg.sv]
// APB-style register file holding the gait configuration.
module gjtg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gjtg_pkg::PADDR_W-1:0]  paddr,
  input  logic [gjtg_pkg::PDATA_W-1:0]  pwdata,
  output logic [gjtg_pkg::PDATA_W-1:0]  prdata,
  output gjtg_pkg::cfg_t                cfg
);

  gjtg_pkg::cfg_t     cfg_r, cfg_nxt;
  gjtg_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = gjtg_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        gjtg_pkg::REG_NEUTRAL_SHOULDER: cfg_nxt.neutral_shoulder = pwdata[15:0];
        gjtg_pkg::REG_NEUTRAL_KNEE:     cfg_nxt.neutral_knee     = pwdata[15:0];
        gjtg_pkg::REG_ACTION_GAIN:      cfg_nxt.action_gain      = pwdata[14:0];
        gjtg_pkg::REG_SHOULDER_SWING:   cfg_nxt.shoulder_swing   = pwdata[14:0];
        gjtg_pkg::REG_KNEE_SWING:       cfg_nxt.knee_swing       = pwdata[14:0];
        gjtg_pkg::REG_KNEE_BIAS:        cfg_nxt.knee_bias        = pwdata[15:0];
        gjtg_pkg::REG_PHASE_STEP:       cfg_nxt.phase_step       = pwdata[15:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_shoulder <= gjtg_pkg::RST_NEUTRAL_SHOULDER;
      cfg_r.neutral_knee     <= gjtg_pkg::RST_NEUTRAL_KNEE;
      cfg_r.action_gain      <= gjtg_pkg::RST_ACTION_GAIN;
      cfg_r.shoulder_swing   <= gjtg_pkg::RST_SHOULDER_SWING;
      cfg_r.knee_swing       <= gjtg_pkg::RST_KNEE_SWING;
      cfg_r.knee_bias        <= gjtg_pkg::RST_KNEE_BIAS;
      cfg_r.phase_step       <= gjtg_pkg::RST_PHASE_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      gjtg_pkg::REG_NEUTRAL_SHOULDER: prdata = {16'd0, cfg_r.neutral_shoulder};
      gjtg_pkg::REG_NEUTRAL_KNEE:     prdata = {16'd0, cfg_r.neutral_knee};
      gjtg_pkg::REG_ACTION_GAIN:      prdata = {17'd0, cfg_r.action_gain};
      gjtg_pkg::REG_SHOULDER_SWING:   prdata = {17'd0, cfg_r.shoulder_swing};
      gjtg_pkg::REG_KNEE_SWING:       prdata = {17'd0, cfg_r.knee_swing};
      gjtg_pkg::REG_KNEE_BIAS:        prdata = {16'd0, cfg_r.knee_bias};
      gjtg_pkg::REG_PHASE_STEP:       prdata = {16'd0, cfg_r.phase_step};
      default:                        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/gjtg_front.sv]
// Front end: accepts action beats, clips them and looks up sine/cosine of the gait phase.
module gjtg_front #(
  parameter int SINE_TABLE_DEPTH = gjtg_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int PHASE_BITS       = gjtg_pkg::DEF_PHASE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gjtg_pkg::in_t       in_data,
  input  logic [15:0]         phase_step,
  input  logic                q_full,
  output logic                q_push,
  output gjtg_pkg::qent_t     q_wdata
);

  localparam int IW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int TW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = PHASE_BITS + IW;

  localparam logic [PW-1:0] FOUR_D  = PW'(4 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] QUAD_1  = IW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] QUAD_2  = IW'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] QUAD_3  = IW'(3 * SINE_TABLE_DEPTH);
  localparam logic [TW-1:0] D_TW    = TW'(SINE_TABLE_DEPTH);

  typedef logic [14:0] tab_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave table, round(16384*sin(pi/2*k/D)), from a fixed-point Taylor series
  function automatic tab_t build_tab();
    tab_t            t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (gjtg_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / gjtg_pkg::TAYLOR_DIV[n];
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * 64'sd16384 + 64'sd536870912) >>> 30;
      if (v > 16384) v = 16384;
      t[k] = 15'(v);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PW-1:0]         scaled;
  logic [IW-1:0]         idx, off_full;
  logic [1:0]            quad;
  logic [TW-1:0]         off, off_rev;
  logic [14:0]           t_fwd, t_rev;
  logic signed [15:0]    fwd_s, rev_s, sine, cosine;
  logic signed [15:0]    act_in [gjtg_pkg::NUM_JOINTS];

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign phase_nxt = q_push ? phase_r + PHASE_BITS'(phase_step) : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Table index = floor(phase * 4D / 2^PHASE_BITS)
  assign scaled = PW'(phase_r) * FOUR_D;
  assign idx    = scaled[PW-1:PHASE_BITS];

  always_comb begin
    if (idx >= QUAD_3) begin
      quad = 2'd3; off_full = idx - QUAD_3;
    end else if (idx >= QUAD_2) begin
      quad = 2'd2; off_full = idx - QUAD_2;
    end else if (idx >= QUAD_1) begin
      quad = 2'd1; off_full = idx - QUAD_1;
    end else begin
      quad = 2'd0; off_full = idx;
    end
  end

  assign off     = TW'(off_full);
  assign off_rev = D_TW - off;
  assign t_fwd   = SINE_TAB[off];
  assign t_rev   = SINE_TAB[off_rev];
  assign fwd_s   = $signed({1'b0, t_fwd});
  assign rev_s   = $signed({1'b0, t_rev});

  // Cosine sits one quadrant ahead of sine with the same offset
  always_comb begin
    case (quad)
      2'd0:    begin sine = fwd_s;  cosine = rev_s;  end
      2'd1:    begin sine = rev_s;  cosine = -fwd_s; end
      2'd2:    begin sine = -fwd_s; cosine = -rev_s; end
      default: begin sine = -rev_s; cosine = fwd_s;  end
    endcase
  end

  assign act_in[0] = in_data.joint0_action;
  assign act_in[1] = in_data.joint1_action;
  assign act_in[2] = in_data.joint2_action;
  assign act_in[3] = in_data.joint3_action;
  assign act_in[4] = in_data.joint4_action;
  assign act_in[5] = in_data.joint5_action;
  assign act_in[6] = in_data.joint6_action;
  assign act_in[7] = in_data.joint7_action;

  always_comb begin
    for (int j = 0; j < gjtg_pkg::NUM_JOINTS; j++) begin
      if (act_in[j] > gjtg_pkg::ACT_POS_LIM)
        q_wdata.act[j] = gjtg_pkg::ACT_W'(gjtg_pkg::ACT_POS_LIM);
      else if (act_in[j] < gjtg_pkg::ACT_NEG_LIM)
        q_wdata.act[j] = gjtg_pkg::ACT_W'(gjtg_pkg::ACT_NEG_LIM);
      else
        q_wdata.act[j] = gjtg_pkg::ACT_W'(act_in[j]);
    end
    q_wdata.sine_v   = sine;
    q_wdata.cosine_v = cosine;
  end

endmodule

[rtl/gjtg_queue.sv]
// Two-beat queue between the front end and the target datapath.
module gjtg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gjtg_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output gjtg_pkg::qent_t rdata,
  output logic            not_empty
);

  localparam int PTR_W = $clog2(gjtg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(gjtg_pkg::QUEUE_DEPTH + 1);

  gjtg_pkg::qent_t    mem_r [gjtg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(gjtg_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/gjtg_back.sv]
// Back end: swing and action products, then round, saturate and register the targets.
module gjtg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  gjtg_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_pop,
  input  gjtg_pkg::qent_t q_rdata,
  output logic            out_valid,
  input  logic            out_ready,
  output gjtg_pkg::out_t  out_data
);

  localparam int SW = 36;

  logic               p_vld_r, p_vld_nxt, out_vld_r, out_vld_nxt;
  logic               out_free, p_take, out_load;

  logic signed [16:0] csum_pos, csum_neg;
  logic signed [31:0] sh_prod, sh_prod_r;
  logic signed [32:0] knp_prod, knp_prod_r, knn_prod, knn_prod_r;
  logic signed [30:0] act_prod [gjtg_pkg::NUM_JOINTS];
  logic signed [30:0] act_prod_r [gjtg_pkg::NUM_JOINTS];
  logic signed [15:0] sine_r, cosine_r;

  logic signed [SW-1:0] ns_base, nk_base, sh_pos, sh_neg, kn_pos, kn_neg;
  logic signed [SW-1:0] sum [gjtg_pkg::NUM_JOINTS];
  logic signed [SW-1:0] rnd [gjtg_pkg::NUM_JOINTS];
  logic signed [15:0]   tgt [gjtg_pkg::NUM_JOINTS];
  gjtg_pkg::out_t       out_r, out_nxt;

  assign out_free = !out_vld_r || out_ready;
  assign p_take   = q_valid && (!p_vld_r || out_free);
  assign out_load = p_vld_r && out_free;
  assign q_pop    = p_take;

  always_comb begin
    p_vld_nxt = p_vld_r;
    if (p_take)        p_vld_nxt = 1'b1;
    else if (out_free) p_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (out_load)       out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  // Product stage
  assign csum_pos = 17'(q_rdata.cosine_v) + 17'(cfg.knee_bias);
  assign csum_neg = 17'(cfg.knee_bias) - 17'(q_rdata.cosine_v);
  assign sh_prod  = $signed({1'b0, cfg.shoulder_swing}) * q_rdata.sine_v;
  assign knp_prod = $signed({1'b0, cfg.knee_swing}) * csum_pos;
  assign knn_prod = $signed({1'b0, cfg.knee_swing}) * csum_neg;

  always_comb begin
    for (int j = 0; j < gjtg_pkg::NUM_JOINTS; j++) begin
      act_prod[j] = $signed({1'b0, cfg.action_gain}) * $signed(q_rdata.act[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (p_take) begin
      sh_prod_r  <= sh_prod;
      knp_prod_r <= knp_prod;
      knn_prod_r <= knn_prod;
      act_prod_r <= act_prod;
      sine_r     <= q_rdata.sine_v;
      cosine_r   <= q_rdata.cosine_v;
    end
  end

  // Sum stage: everything at 26 fractional bits, round half up to Q3.12, clamp
  assign ns_base = SW'(cfg.neutral_shoulder) <<< 14;
  assign nk_base = SW'(cfg.neutral_knee) <<< 14;
  assign sh_pos  = ns_base + SW'(sh_prod_r);
  assign sh_neg  = ns_base - SW'(sh_prod_r);
  assign kn_pos  = nk_base + SW'(knp_prod_r);
  assign kn_neg  = nk_base + SW'(knn_prod_r);

  always_comb begin
    for (int j = 0; j < gjtg_pkg::NUM_JOINTS; j++) begin
      // diagonal trot: 0 and 6 lead, 2 and 4 oppose; knees 1 and 7 lead, 3 and 5 oppose
      case (j) inside
        0, 6:    sum[j] = sh_pos;
        2, 4:    sum[j] = sh_neg;
        1, 7:    sum[j] = kn_pos;
        default: sum[j] = kn_neg;
      endcase
      sum[j] = sum[j] + (SW'(act_prod_r[j]) <<< 1) + SW'(8192);
      rnd[j] = sum[j] >>> 14;
      if (rnd[j] > SW'(32767))       tgt[j] = 16'sh7fff;
      else if (rnd[j] < -SW'(32768)) tgt[j] = 16'sh8000;
      else                           tgt[j] = 16'(rnd[j]);
    end
  end

  always_comb begin
    out_nxt.joint0_target = tgt[0];
    out_nxt.joint1_target = tgt[1];
    out_nxt.joint2_target = tgt[2];
    out_nxt.joint3_target = tgt[3];
    out_nxt.joint4_target = tgt[4];
    out_nxt.joint5_target = tgt[5];
    out_nxt.joint6_target = tgt[6];
    out_nxt.joint7_target = tgt[7];
    out_nxt.phase_sine    = sine_r;
    out_nxt.phase_cosine  = cosine_r;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[rtl/gjtg_checker.sv]
// Port-level checks for the gait joint target generator, bound to the top level.
module gjtg_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gjtg_pkg::out_t out_data,
  input logic           pready
);

  // Reset empties the output register
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // The input side only backs up once the output has been stalled
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind gait_joint_target_generator_core gjtg_checker u_gjtg_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the gait joint target generator core.
module tb;

  localparam int TABLE_DEPTH  = gjtg_pkg::DEF_SINE_TABLE_DEPTH;
  localparam int PHASE_W      = gjtg_pkg::DEF_PHASE_BITS;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [2:0] UNMAPPED_IDX = 3'd7;

  localparam logic [15:0] ACTION_EDGES [10] = '{16'h2000, 16'he000, 16'h1fff, 16'he001,
                                                16'h2001, 16'hdfff, 16'h7fff, 16'h8000,
                                                16'h0000, 16'hffff};

  class joint_target_tracker;
    logic signed [15:0] neutral_shoulder, neutral_knee, knee_bias;
    logic        [14:0] action_gain, shoulder_swing, knee_swing;
    logic        [15:0] phase_step;
    logic [PHASE_W-1:0] gait_phase;
    longint             quarter_sine [0:TABLE_DEPTH];
    gjtg_pkg::out_t     pending_targets [$];
    int                 errors;

    function new();
      longint unsigned x, x2, term;
      longint          acc, v;
      // quarter-wave table from a fixed-point Taylor series in Q2.30
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        x    = (gjtg_pkg::HALF_PI_Q30 * longint'(k)) / TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        v = (acc * 16384 + (longint'(1) << 29)) >>> 30;
        quarter_sine[k] = (v > 16384) ? 16384 : v;
      end
      neutral_shoulder = gjtg_pkg::RST_NEUTRAL_SHOULDER;
      neutral_knee     = gjtg_pkg::RST_NEUTRAL_KNEE;
      action_gain      = gjtg_pkg::RST_ACTION_GAIN;
      shoulder_swing   = gjtg_pkg::RST_SHOULDER_SWING;
      knee_swing       = gjtg_pkg::RST_KNEE_SWING;
      knee_bias        = gjtg_pkg::RST_KNEE_BIAS;
      phase_step       = gjtg_pkg::RST_PHASE_STEP;
      gait_phase       = '0;
      errors           = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        gjtg_pkg::REG_NEUTRAL_SHOULDER: neutral_shoulder = value[15:0];
        gjtg_pkg::REG_NEUTRAL_KNEE:     neutral_knee     = value[15:0];
        gjtg_pkg::REG_ACTION_GAIN:      action_gain      = value[14:0];
        gjtg_pkg::REG_SHOULDER_SWING:   shoulder_swing   = value[14:0];
        gjtg_pkg::REG_KNEE_SWING:       knee_swing       = value[14:0];
        gjtg_pkg::REG_KNEE_BIAS:        knee_bias        = value[15:0];
        gjtg_pkg::REG_PHASE_STEP:       phase_step       = value[15:0];
        default: ;
      endcase
    endfunction

    function longint trig_at(longint unsigned idx);
      longint unsigned r;
      idx = idx % (4 * TABLE_DEPTH);
      r   = idx % TABLE_DEPTH;
      case (idx / TABLE_DEPTH)
        0:       return quarter_sine[r];
        1:       return quarter_sine[TABLE_DEPTH - r];
        2:       return -quarter_sine[r];
        default: return -quarter_sine[TABLE_DEPTH - r];
      endcase
    endfunction

    function void take_actions(gjtg_pkg::in_t beat);
      logic [7:0][15:0] acts;
      logic [9:0][15:0] row;
      longint           s, c, sh_pos, sh_neg, kn_pos, kn_neg, a, base, tgt;
      longint unsigned  idx;
      acts   = beat;
      idx    = (longint'(gait_phase) * 4 * TABLE_DEPTH) >> PHASE_W;
      s      = trig_at(idx);
      c      = trig_at(idx + TABLE_DEPTH);
      sh_pos = longint'(neutral_shoulder) * 16384 + longint'(shoulder_swing) * s;
      sh_neg = longint'(neutral_shoulder) * 16384 - longint'(shoulder_swing) * s;
      kn_pos = longint'(neutral_knee) * 16384
               + longint'(knee_swing) * (c + longint'(knee_bias));
      kn_neg = longint'(neutral_knee) * 16384
               + longint'(knee_swing) * (longint'(knee_bias) - c);
      for (int j = 0; j < gjtg_pkg::NUM_JOINTS; j++) begin
        a = longint'($signed(acts[gjtg_pkg::NUM_JOINTS - 1 - j]));
        if (a > gjtg_pkg::ACT_POS_LIM) a = gjtg_pkg::ACT_POS_LIM;
        if (a < gjtg_pkg::ACT_NEG_LIM) a = gjtg_pkg::ACT_NEG_LIM;
        // diagonal trot: shoulders 0/6 and knees 1/7 in phase, the others opposed
        case (j)
          0, 6:    base = sh_pos;
          2, 4:    base = sh_neg;
          1, 7:    base = kn_pos;
          default: base = kn_neg;
        endcase
        tgt = (base + a * longint'(action_gain) * 2 + 8192) >>> 14;
        if (tgt > 32767) tgt = 32767;
        else if (tgt < -32768) tgt = -32768;
        row[9 - j] = 16'(tgt);
      end
      row[1] = 16'(s);
      row[0] = 16'(c);
      pending_targets.push_back(gjtg_pkg::out_t'(row));
      gait_phase = gait_phase + phase_step;
    endfunction

    function void check_targets(gjtg_pkg::out_t got);
      string            names [10] = '{"joint0_target", "joint1_target", "joint2_target",
                                       "joint3_target", "joint4_target", "joint5_target",
                                       "joint6_target", "joint7_target", "phase_sine",
                                       "phase_cosine"};
      logic [9:0][15:0] want_row, got_row;
      if (pending_targets.size() == 0) begin
        $display("%0t: target beat with nothing pending, expected none got %h", $time, got);
        errors++;
        return;
      end
      want_row = pending_targets.pop_front();
      got_row  = got;
      for (int f = 0; f < 10; f++)
        if (got_row[9 - f] !== want_row[9 - f]) begin
          $display("%0t: %s mismatch, expected %0d got %0d", $time, names[f],
                   $signed(want_row[9 - f]), $signed(got_row[9 - f]));
          errors++;
        end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid, in_ready;
  gjtg_pkg::in_t                in_data;
  logic                         out_valid, out_ready;
  gjtg_pkg::out_t               out_data;
  logic                         psel, penable, pwrite, pready;
  logic [gjtg_pkg::PADDR_W-1:0] paddr;
  logic [gjtg_pkg::PDATA_W-1:0] pwdata, prdata;

  joint_target_tracker board;
  bit                  calm     = 1'b0;
  bit                  hold_out = 1'b0;
  int                  cycle_count = 0;

  gait_joint_target_generator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready) board.set_register(paddr[4:2], pwdata);
      if (in_valid && in_ready) board.take_actions(in_data);
      if (out_valid && out_ready) board.check_targets(out_data);
    end
  end

  // result side: random stalls, one long hold on request, none once calm
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send_actions(input gjtg_pkg::in_t beat);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_targets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(input logic [2:0] idx);
    logic [15:0] lo;
    logic [31:0] v;
    int          roll;
    bit          junk;
    roll = $urandom_range(0, 7);
    junk = ($urandom_range(0, 3) == 0);
    case (idx)
      gjtg_pkg::REG_NEUTRAL_SHOULDER, gjtg_pkg::REG_NEUTRAL_KNEE:
        lo = (roll == 0) ? 16'h8000 : (roll == 1) ? 16'h7fff :
             16'(int'($urandom_range(0, 16384)) - 8192);
      gjtg_pkg::REG_ACTION_GAIN:
        lo = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'h7fff : 16'($urandom_range(0, 2048));
      gjtg_pkg::REG_SHOULDER_SWING, gjtg_pkg::REG_KNEE_SWING:
        lo = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'h7fff : 16'($urandom_range(0, 4096));
      gjtg_pkg::REG_KNEE_BIAS:
        lo = (roll == 0) ? 16'h8000 : (roll == 1) ? 16'h7fff :
             16'(int'($urandom_range(0, 32768)) - 16384);
      default:
        lo = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hffff : 16'($urandom);
    endcase
    // stray upper bits must be dropped by the register
    if (junk && (idx == gjtg_pkg::REG_ACTION_GAIN || idx == gjtg_pkg::REG_SHOULDER_SWING ||
                 idx == gjtg_pkg::REG_KNEE_SWING))
      lo[15] = 1'b1;
    v = {16'h0000, lo};
    if (junk) v[31:16] = 16'($urandom);
    return v;
  endfunction

  function automatic gjtg_pkg::in_t rand_actions();
    logic [7:0][15:0] acts;
    for (int j = 0; j < gjtg_pkg::NUM_JOINTS; j++)
      case ($urandom_range(0, 3))
        0:       acts[j] = 16'($urandom);
        1, 2:    acts[j] = 16'(int'($urandom_range(0, 16384)) - 8192);
        default: acts[j] = ACTION_EDGES[$urandom_range(0, 9)];
      endcase
    return gjtg_pkg::in_t'(acts);
  endfunction

  initial begin
    board   = new();
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: clip limits, either side of them and bit patterns
    send_actions('0);
    send_actions({8{gjtg_pkg::ACT_POS_LIM}});
    send_actions({8{gjtg_pkg::ACT_NEG_LIM}});
    send_actions({8{16'h7fff}});
    send_actions({8{16'h8000}});
    send_actions({4{16'sd8193, -16'sd8193}});
    send_actions({4{-16'sd8191, 16'sd8191}});
    send_actions({16'sd1, -16'sd1, 16'sd100, -16'sd4096, 16'sd4095, -16'sd100, 16'sd2, -16'sd2});
    send_actions({4{16'h5555, 16'haaaa}});
    send_actions({4{16'haaaa, 16'h5555}});

    // everything at its top, knee bias beyond one, phase wrapping backwards
    drain();
    apb_write(gjtg_pkg::REG_NEUTRAL_SHOULDER, 32'h0000_7fff);
    apb_write(gjtg_pkg::REG_NEUTRAL_KNEE,     32'h0000_7fff);
    apb_write(gjtg_pkg::REG_ACTION_GAIN,      32'h0000_7fff);
    apb_write(gjtg_pkg::REG_SHOULDER_SWING,   32'h0000_7fff);
    apb_write(gjtg_pkg::REG_KNEE_SWING,       32'h0000_7fff);
    apb_write(gjtg_pkg::REG_KNEE_BIAS,        32'h0000_7fff);
    apb_write(gjtg_pkg::REG_PHASE_STEP,       32'h0000_ffff);
    send_actions('0);
    send_actions({8{gjtg_pkg::ACT_POS_LIM}});
    send_actions({8{gjtg_pkg::ACT_NEG_LIM}});
    send_actions({8{16'h7fff}});
    repeat (3) send_actions(rand_actions());

    // neutrals, gain and knee bias at their bottom, swings at their top, quarter-cycle steps, write to an unmapped slot
    drain();
    apb_write(gjtg_pkg::REG_NEUTRAL_SHOULDER, 32'h0000_8000);
    apb_write(gjtg_pkg::REG_NEUTRAL_KNEE,     32'h0000_8000);
    apb_write(gjtg_pkg::REG_ACTION_GAIN,      32'h0000_0000);
    apb_write(gjtg_pkg::REG_SHOULDER_SWING,   32'h0000_7fff);
    apb_write(gjtg_pkg::REG_KNEE_SWING,       32'h0000_7fff);
    apb_write(gjtg_pkg::REG_KNEE_BIAS,        32'h0000_8000);
    apb_write(gjtg_pkg::REG_PHASE_STEP,       32'h0000_4000);
    apb_write(UNMAPPED_IDX,                   $urandom);
    send_actions('0);
    send_actions({8{gjtg_pkg::ACT_POS_LIM}});
    send_actions({8{gjtg_pkg::ACT_NEG_LIM}});
    send_actions({8{16'h8000}});
    send_actions(rand_actions());

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      if (p == RAND_PHASES - 1) calm = 1'b1;
      for (int r = gjtg_pkg::REG_NEUTRAL_SHOULDER; r <= gjtg_pkg::REG_PHASE_STEP; r++)
        apb_write(3'(r), pick_value(3'(r)));
      // hold the result side so the queue fills and the input stalls
      if (p == 2) hold_out = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) drain();
        send_actions(rand_actions());
      end
    end
    drain();

    if (board.errors == 0 && board.pending_targets.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/gjtg_pkg.sv
rtl/gjtg_cfg.sv
rtl/gjtg_front.sv
rtl/gjtg_queue.sv
rtl/gjtg_back.sv
rtl/gait_joint_target_generator_core.sv
rtl/gjtg_checker.sv
tb/tb.sv
